[rtl/acsv_pkg.sv]
// Package for the angle cluster symbol vote block.
// Holds shared constants, register indexes and the controller command struct.
// No dependencies.
`default_nettype none
package acsv_pkg;

	localparam int MAX_CANDIDATES_DEF = 64;
	localparam logic [8:0] WRAP_DEGREES = 9'd360;
	localparam logic [7:0] NO_SYMBOL = 8'd95;

	localparam logic [6:0] MIN_SET_RST = 7'd5;
	localparam logic [6:0] MIN_GROUP_RST = 7'd4;
	localparam logic [8:0] GROUP_SEP_RST = 9'd30;

	localparam logic [1:0] REG_MIN_SET = 2'd0;
	localparam logic [1:0] REG_MIN_GROUP = 2'd1;
	localparam logic [1:0] REG_GROUP_SEP = 2'd2;

	localparam logic CMD_ADD = 1'b0;
	localparam logic CMD_DECIDE = 1'b1;

	typedef struct packed {
		logic wr;
		logic clr;
		logic rd_en;
		logic tgt_load;
		logic walk_start;
		logic walk_step;
		logic walk_end;
		logic upd;
		logic dec_start;
	} acsv_cmd_t;

endpackage
`default_nettype wire

[rtl/acsv_dp.sv]
// Datapath: candidate store, per-symbol run walk and winner tracking.
// Depends on acsv_pkg; driven by acsv_ctrl commands.
`default_nettype none
module acsv_dp #(
	parameter int N = acsv_pkg::MAX_CANDIDATES_DEF,
	parameter int AW = (N > 1) ? $clog2(N) : 1,
	parameter int CW = $clog2(N + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire acsv_pkg::acsv_cmd_t cmd,
	input  wire logic [AW-1:0]     rd_addr,
	input  wire logic [7:0]        wr_symbol,
	input  wire logic [8:0]        wr_angle,
	input  wire logic [6:0]        min_set_size,
	input  wire logic [6:0]        min_group_size,
	input  wire logic [8:0]        group_separation,
	output logic [CW-1:0]          count,
	output logic [7:0]             winner
);
	import acsv_pkg::*;

	localparam int CMPW = (CW > 7) ? CW : 7;

	logic [7:0] sym_mem [N];
	logic [8:0] ang_mem [N];
	logic [CW-1:0] count_q;
	logic [7:0] rd_sym_q;
	logic [8:0] rd_ang_q;

	logic [7:0] tgt_q;
	logic [1:0] runs_q;
	logic [CW-1:0] cur_q, first_q, mid_q, cnt_q, hits_q;
	logic [8:0] fa_q, la_q;

	logic [CW-1:0] ba_h_q, bq_h_q;
	logic [7:0] ba_s_q, bq_s_q;
	logic discard_q;

	function automatic logic [CW-1:0] kept(input logic [CW-1:0] len, input logic [6:0] m);
		return (CMPW'(len) >= CMPW'(m)) ? len : '0;
	endfunction

	logic [8:0] adiff;
	logic near;
	logic signed [10:0] wd, wabs;
	logic wrap_near;
	logic [CW-1:0] hits_d;
	logic qual;

	assign adiff = (la_q > rd_ang_q) ? (la_q - rd_ang_q) : (rd_ang_q - la_q);
	assign near = adiff < group_separation;
	assign wd = $signed({2'b00, fa_q}) - $signed({2'b00, la_q}) + $signed({2'b00, WRAP_DEGREES});
	assign wabs = (wd < 0) ? -wd : wd;
	assign wrap_near = wabs < $signed({2'b00, group_separation});
	assign qual = CMPW'(cnt_q) >= CMPW'(min_set_size);

	always_comb begin
		if (runs_q == 2'd0) begin
			hits_d = '0;
		end else if (runs_q == 2'd1) begin
			hits_d = kept(cur_q, min_group_size);
		end else if (wrap_near) begin
			hits_d = mid_q + kept(first_q + cur_q, min_group_size);
		end else begin
			hits_d = mid_q + kept(first_q, min_group_size) + kept(cur_q, min_group_size);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr && count_q < CW'(N)) begin
			sym_mem[count_q[AW-1:0]] <= wr_symbol;
			ang_mem[count_q[AW-1:0]] <= wr_angle;
		end
		if (cmd.rd_en) begin
			rd_sym_q <= sym_mem[rd_addr];
			rd_ang_q <= ang_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clr) begin
			count_q <= '0;
		end else if (cmd.wr && count_q < CW'(N)) begin
			count_q <= count_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tgt_load) begin
			tgt_q <= rd_sym_q;
		end
		if (cmd.walk_start) begin
			runs_q <= 2'd0;
			cur_q <= '0;
			first_q <= '0;
			mid_q <= '0;
			cnt_q <= '0;
			fa_q <= '0;
			la_q <= '0;
		end else if (cmd.walk_step && rd_sym_q == tgt_q) begin
			cnt_q <= cnt_q + 1'b1;
			la_q <= rd_ang_q;
			if (runs_q == 2'd0) begin
				runs_q <= 2'd1;
				cur_q <= CW'(1);
				fa_q <= rd_ang_q;
			end else if (near) begin
				cur_q <= cur_q + 1'b1;
			end else begin
				if (runs_q == 2'd1) begin
					first_q <= cur_q;
				end else begin
					mid_q <= mid_q + kept(cur_q, min_group_size);
				end
				runs_q <= 2'd2;
				cur_q <= CW'(1);
			end
		end
		if (cmd.walk_end) begin
			hits_q <= hits_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ba_h_q <= '0;
			bq_h_q <= '0;
			ba_s_q <= NO_SYMBOL;
			bq_s_q <= NO_SYMBOL;
			discard_q <= 1'b0;
		end else if (cmd.dec_start) begin
			ba_h_q <= '0;
			bq_h_q <= '0;
			ba_s_q <= NO_SYMBOL;
			bq_s_q <= NO_SYMBOL;
			discard_q <= 1'b0;
		end else if (cmd.upd) begin
			if (hits_q > ba_h_q || (hits_q == ba_h_q && hits_q != '0 && tgt_q < ba_s_q)) begin
				ba_h_q <= hits_q;
				ba_s_q <= tgt_q;
			end
			if (qual) begin
				discard_q <= 1'b1;
				if (hits_q > bq_h_q || (hits_q == bq_h_q && hits_q != '0 && tgt_q < bq_s_q)) begin
					bq_h_q <= hits_q;
					bq_s_q <= tgt_q;
				end
			end
		end
	end

	assign count = count_q;
	always_comb begin
		if (discard_q) begin
			winner = (bq_h_q != '0) ? bq_s_q : NO_SYMBOL;
		end else begin
			winner = (ba_h_q != '0) ? ba_s_q : NO_SYMBOL;
		end
	end

endmodule
`default_nettype wire

[rtl/acsv_ctrl.sv]
// Controller: intake handshake, decide sequencing over store entries, result beat.
// Depends on acsv_pkg; commands acsv_dp.
`default_nettype none
module acsv_ctrl #(
	parameter int N = acsv_pkg::MAX_CANDIDATES_DEF,
	parameter int AW = (N > 1) ? $clog2(N) : 1,
	parameter int CW = $clog2(N + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              command,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire logic [CW-1:0]     count,
	output acsv_pkg::acsv_cmd_t    cmd,
	output logic [AW-1:0]          rd_addr
);
	import acsv_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_RDJ, S_TGT, S_WRD, S_WSTEP, S_FIN, S_UPD, S_OUT
	} state_t;

	state_t state_q;
	logic [CW-1:0] j_q, i_q;
	logic acc;

	assign in_ready = (state_q == S_IDLE) || (state_q == S_OUT && command == CMD_ADD);
	assign acc = in_valid && in_ready;
	assign out_valid = (state_q == S_OUT);
	assign rd_addr = (state_q == S_RDJ) ? j_q[AW-1:0] : i_q[AW-1:0];

	always_comb begin
		cmd = '0;
		cmd.wr = acc && command == CMD_ADD;
		cmd.dec_start = acc && command == CMD_DECIDE;
		cmd.clr = (acc && command == CMD_DECIDE && count == '0)
			|| (state_q == S_UPD && CW'(j_q + 1'b1) == count);
		cmd.rd_en = (state_q == S_RDJ) || (state_q == S_WRD);
		cmd.tgt_load = (state_q == S_TGT);
		cmd.walk_start = (state_q == S_TGT);
		cmd.walk_step = (state_q == S_WSTEP);
		cmd.walk_end = (state_q == S_FIN);
		cmd.upd = (state_q == S_UPD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			j_q <= '0;
			i_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (acc && command == CMD_DECIDE) begin
						j_q <= '0;
						state_q <= (count == '0) ? S_OUT : S_RDJ;
					end
				end
				S_RDJ: state_q <= S_TGT;
				S_TGT: begin
					i_q <= '0;
					state_q <= S_WRD;
				end
				S_WRD: state_q <= S_WSTEP;
				S_WSTEP: begin
					if (CW'(i_q + 1'b1) == count) begin
						state_q <= S_FIN;
					end else begin
						i_q <= i_q + 1'b1;
						state_q <= S_WRD;
					end
				end
				S_FIN: state_q <= S_UPD;
				S_UPD: begin
					if (CW'(j_q + 1'b1) == count) begin
						state_q <= S_OUT;
					end else begin
						j_q <= j_q + 1'b1;
						state_q <= S_RDJ;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_wr_clr: assert property (@(posedge clk) disable iff (!arst_n) !(cmd.wr && cmd.clr))
		else $error("write and clear together");
	a_out_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(cmd.walk_step || cmd.walk_end || cmd.upd))
		else $error("walk active during result beat");
	a_dec_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && command == CMD_DECIDE && count != '0) |=> state_q == S_RDJ)
		else $error("decide did not start walk");
	a_upd_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd |-> $past(cmd.walk_end))
		else $error("update without walk end");

endmodule
`default_nettype wire

[rtl/angle_cluster_symbol_vote.sv]
// Decide beat: for each of the n stored candidates, the one store read port is walked
// once over every stored entry.
// One decide at a time; adds are taken while a result beat waits.
// Reset clears the entry count, result state and config to 5 / 4 / 30.
// Top level: APB config registers, acsv_ctrl and acsv_dp. Uses acsv_pkg.
`default_nettype none
module angle_cluster_symbol_vote #(
	parameter int MAX_CANDIDATES = acsv_pkg::MAX_CANDIDATES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        command,
	input  wire logic [7:0]  symbol_code,
	input  wire logic [8:0]  angle,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       chosen_symbol
);
	import acsv_pkg::*;

	localparam int AW = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
	localparam int CW = $clog2(MAX_CANDIDATES + 1);

	logic [6:0] mss_q, mgs_q;
	logic [8:0] sep_q;
	acsv_cmd_t cmd;
	logic [AW-1:0] rd_addr;
	logic [CW-1:0] count;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mss_q <= MIN_SET_RST;
			mgs_q <= MIN_GROUP_RST;
			sep_q <= GROUP_SEP_RST;
		end else if (psel && penable && pwrite) begin
			if (paddr[3:2] == REG_MIN_SET) mss_q <= pwdata[6:0];
			if (paddr[3:2] == REG_MIN_GROUP) mgs_q <= pwdata[6:0];
			if (paddr[3:2] == REG_GROUP_SEP) sep_q <= pwdata[8:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[3:2] == REG_MIN_SET) prdata = {25'd0, mss_q};
		else if (paddr[3:2] == REG_MIN_GROUP) prdata = {25'd0, mgs_q};
		else if (paddr[3:2] == REG_GROUP_SEP) prdata = {23'd0, sep_q};
	end

	acsv_ctrl #(.N(MAX_CANDIDATES), .AW(AW), .CW(CW)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .command(command),
		.out_valid(out_valid), .out_ready(out_ready),
		.count(count), .cmd(cmd), .rd_addr(rd_addr)
	);

	acsv_dp #(.N(MAX_CANDIDATES), .AW(AW), .CW(CW)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .rd_addr(rd_addr),
		.wr_symbol(symbol_code), .wr_angle(angle),
		.min_set_size(mss_q), .min_group_size(mgs_q), .group_separation(sep_q),
		.count(count), .winner(chosen_symbol)
	);

endmodule
`default_nettype wire
